/* rtl/core/assert_macros.svh */
// Assertion macros used by the ring window sum and mean unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RWSM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
`define RWSM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`define RWSM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define RWSM_ASSERT(lbl, clk, rst, prop)
`define RWSM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RWSM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/rwsm_pkg.sv */
// Package: widths, codes and state type of the ring window sum and mean unit.
`default_nettype none
package rwsm_pkg;
   localparam int DEPTH_DEFAULT = 64;
   localparam int SAMPLE_W      = 32;
   localparam int SUM_W         = 38;
   localparam int MEAN_W        = 48;
   localparam int FRAC_W        = 16;
   localparam int WIN_W         = 7;
   localparam int FILL_W        = 7;
   localparam int DVD_W         = SUM_W + FRAC_W;
   localparam int RSP_FIELDS_W  = 2 * SUM_W + 2 * MEAN_W + SAMPLE_W + FILL_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd64;

   typedef enum logic {
      OP_PUSH  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV_RECENT,
      ST_DIV_TOTAL,
      ST_FINISH
   } state_type;
endpackage
`default_nettype wire

/* rtl/core/ring_window_sum_mean_unit.sv */
// Ring window sum and mean unit: push/clear items in, one statistics item out.
//
// Input channel (req_*): one item per sample push or ring clear. The unit
// takes an item only while idle, then walks the stored samples newest first
// through the ring RAM, one read per cycle, building the window sum and the
// total sum, and runs the Q.16 means (the window mean only for a nonzero
// window) through one shared restoring divider, one quotient bit per cycle,
// 54 steps per mean. A push runs the RAM walk and the divider passes; a clear
// goes straight to the result. The unit takes no new item until the result
// is loaded and it is idle again.
// Result channel (rsp_*): one item per input item, held in an output register;
// the next input item is taken while a result still waits. If the receiver
// stalls, the finished result of the following item waits inside the unit.
// Configuration (csr_*): window length, always ready. The user writes it only
// while idle; the unit does not enforce this.
// Reset (synchronous): empty ring, window length 64, no result pending.
// The ring RAM is not cleared; only written entries are ever read.
`default_nettype none
`include "assert_macros.svh"
module ring_window_sum_mean_unit #(
   parameter int DEPTH = rwsm_pkg::DEPTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [31:0] sample
   input  wire logic [rwsm_pkg::SAMPLE_W-1:0]   req_tdata,
   // [0] operation
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [37:0] recent_sum, [85:38] recent_mean, [123:86] total_sum,
   // [171:124] total_mean, [203:172] latest_sample, [210:204] fill_count
   output logic      [rwsm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] is_empty
   output logic                                 rsp_tuser,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rwsm_pkg::WIN_W-1:0]      csr_data
);
   import rwsm_pkg::*;

   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int MIN_W   = (COUNT_W > WIN_W) ? COUNT_W : WIN_W;
   localparam logic [ADDR_W-1:0]  ADDR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DEPTH);

   state_type            state_ff, state_in;
   logic [WIN_W-1:0]     window_ff, window_in;
   logic [ADDR_W-1:0]    head_ff, head_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [COUNT_W-1:0]   issued_ff, issued_in;
   logic [COUNT_W-1:0]   taken_ff, taken_in;
   logic                 pending_ff, pending_in;
   logic                 div_issued_ff, div_issued_in;
   logic [SUM_W-1:0]     acc_ff, acc_in;
   logic [SUM_W-1:0]     recent_ff, recent_in;
   logic [SUM_W-1:0]     total_ff, total_in;
   logic [MEAN_W-1:0]    recent_mean_ff, recent_mean_in;
   logic [MEAN_W-1:0]    total_mean_ff, total_mean_in;
   logic [SAMPLE_W-1:0]  latest_ff, latest_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff, rsp_user_in;

   logic                 req_accept;
   logic                 push;
   logic                 issue;
   logic [SUM_W-1:0]     acc_next;
   logic [MIN_W-1:0]     win_ext, cnt_ext;
   logic [COUNT_W-1:0]   window_n;
   logic [SAMPLE_W-1:0]  rd_data;
   logic                 div_start;
   logic [SUM_W-1:0]     div_sum;
   logic [COUNT_W-1:0]   div_divisor;
   logic [MEAN_W-1:0]    div_quotient;
   logic                 div_done;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign push       = req_accept && (op_type'(req_tuser) == OP_PUSH);
   assign csr_ready  = 1'b1;

   assign win_ext  = MIN_W'(window_ff);
   assign cnt_ext  = MIN_W'(count_ff);
   assign window_n = COUNT_W'((win_ext < cnt_ext) ? win_ext : cnt_ext);

   assign issue    = (state_ff == ST_SUM) && (issued_ff != count_ff);
   assign acc_next = acc_ff + SUM_W'(rd_data);

   assign div_sum     = (state_ff == ST_DIV_RECENT) ? recent_ff : total_ff;
   assign div_divisor = (state_ff == ST_DIV_RECENT) ? window_n : count_ff;

   rwsm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (head_ff),
      .wr_data (req_tdata),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   rwsm_divider #(
      .COUNT_W (COUNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sum      (div_sum),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   always_comb begin
      state_in       = state_ff;
      window_in      = window_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      addr_in        = addr_ff;
      issued_in      = issued_ff;
      taken_in       = taken_ff;
      pending_in     = issue;
      div_issued_in  = div_issued_ff;
      acc_in         = acc_ff;
      recent_in      = recent_ff;
      total_in       = total_ff;
      recent_mean_in = recent_mean_ff;
      total_mean_in  = total_mean_ff;
      latest_in      = latest_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      div_start      = 1'b0;

      if (csr_valid && csr_ready) begin
         window_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               acc_in         = '0;
               recent_in      = '0;
               total_in       = '0;
               recent_mean_in = '0;
               total_mean_in  = '0;
               issued_in      = '0;
               taken_in       = '0;
               div_issued_in  = 1'b0;
               if (push) begin
                  addr_in   = head_ff;
                  head_in   = (head_ff == ADDR_LAST) ? '0 : head_ff + 1'b1;
                  count_in  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
                  latest_in = req_tdata;
                  state_in  = ST_SUM;
               end else begin
                  head_in   = '0;
                  count_in  = '0;
                  latest_in = '0;
                  state_in  = ST_FINISH;
               end
            end
         end
         ST_SUM: begin
            if (issue) begin
               addr_in   = (addr_ff == '0) ? ADDR_LAST : addr_ff - 1'b1;
               issued_in = issued_ff + 1'b1;
            end
            if (pending_ff) begin
               acc_in   = acc_next;
               taken_in = taken_ff + 1'b1;
               if (COUNT_W'(taken_ff + 1'b1) == window_n) begin
                  recent_in = acc_next;
               end
            end else if (taken_ff == count_ff) begin
               total_in = acc_ff;
               state_in = ST_DIV_RECENT;
            end
         end
         ST_DIV_RECENT: begin
            if (window_n == '0) begin
               state_in = ST_DIV_TOTAL;
            end else if (!div_issued_ff) begin
               div_start     = 1'b1;
               div_issued_in = 1'b1;
            end else if (div_done) begin
               recent_mean_in = div_quotient;
               div_issued_in  = 1'b0;
               state_in       = ST_DIV_TOTAL;
            end
         end
         ST_DIV_TOTAL: begin
            if (!div_issued_ff) begin
               div_start     = 1'b1;
               div_issued_in = 1'b1;
            end else if (div_done) begin
               total_mean_in = div_quotient;
               div_issued_in = 1'b0;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({FILL_W'(count_ff), latest_ff, total_mean_ff,
                                           total_ff, recent_mean_ff, recent_ff});
               rsp_user_in  = (count_ff == '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_ff     <= WINDOW_RESET;
         head_ff       <= '0;
         count_ff      <= '0;
         addr_ff       <= '0;
         issued_ff     <= '0;
         taken_ff      <= '0;
         pending_ff    <= 1'b0;
         div_issued_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         addr_ff       <= addr_in;
         issued_ff     <= issued_in;
         taken_ff      <= taken_in;
         pending_ff    <= pending_in;
         div_issued_ff <= div_issued_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      acc_ff         <= acc_in;
      recent_ff      <= recent_in;
      total_ff       <= total_in;
      recent_mean_ff <= recent_mean_in;
      total_mean_ff  <= total_mean_in;
      latest_ff      <= latest_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `RWSM_ASSERT(a_fill_bound, clock, reset, count_ff <= COUNT_MAX)
   `RWSM_ASSERT(a_head_bound, clock, reset, head_ff <= ADDR_LAST)
   `RWSM_ASSERT_IMP(a_div_nonzero, clock, reset, div_start, div_divisor != '0)
   `RWSM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_tready)
   `RWSM_ASSERT_IMP(a_empty_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
endmodule
`default_nettype wire

/* rtl/core/rwsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rwsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* rtl/core/rwsm_divider.sv */
// Radix-2 restoring divider: Q.16 mean of a 38-bit sum over a sample count.
`default_nettype none
module rwsm_divider #(
   parameter int COUNT_W = 7
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rwsm_pkg::SUM_W-1:0] sum,
   input  wire logic [COUNT_W-1:0]         divisor,
   output logic      [rwsm_pkg::MEAN_W-1:0] quotient,
   output logic                            done
);
   import rwsm_pkg::*;

   localparam int STEP_W = $clog2(DVD_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [COUNT_W-1:0]   dsr_ff, dsr_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [MEAN_W-1:0]    quo_ff, quo_in;
   logic [COUNT_W:0]     trial;
   logic                 fits;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = {sum, {FRAC_W{1'b0}}};
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         rem_in  = fits ? COUNT_W'(trial - {1'b0, dsr_ff}) : COUNT_W'(trial);
         quo_in  = {quo_ff[MEAN_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule
`default_nettype wire

/* tb/sv/ring_window_sum_mean_unit_checker.sv */
// Checker for the ring window sum and mean unit: tracks ring state and compares every result.
module ring_window_sum_mean_unit_checker
   import rwsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [WIN_W-1:0]      csr_data,
   output int                    mismatches,
   output int                    outstanding,
   output int                    checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH = DEPTH_DEFAULT;
   localparam int HEAD_W     = $clog2(RING_DEPTH);

   localparam int RS_LO = 0;
   localparam int RM_LO = RS_LO + SUM_W;
   localparam int TS_LO = RM_LO + MEAN_W;
   localparam int TM_LO = TS_LO + SUM_W;
   localparam int LS_LO = TM_LO + MEAN_W;
   localparam int FC_LO = LS_LO + SAMPLE_W;

   typedef struct packed {
      logic [SUM_W-1:0]    recent_sum;
      logic [MEAN_W-1:0]   recent_mean;
      logic [SUM_W-1:0]    total_sum;
      logic [MEAN_W-1:0]   total_mean;
      logic [SAMPLE_W-1:0] latest_sample;
      logic [FILL_W-1:0]   fill_count;
      logic                is_empty;
   } window_stats_type;

   logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic [HEAD_W-1:0]   head;
   logic [FILL_W-1:0]   fill;
   logic [WIN_W-1:0]    window;
   window_stats_type    stats_q [$];
   int                  fail_total = 0;
   int                  result_total = 0;

   initial outstanding = 0;

   assign mismatches = fail_total;
   assign checked    = result_total;

   function automatic logic [SUM_W-1:0] newest_sum(logic [FILL_W-1:0] n);
      logic [SUM_W-1:0]  acc;
      logic [HEAD_W-1:0] pos;
      acc = '0;
      pos = head;
      for (int i = 0; i < n; i++) begin
         pos = pos - 1'b1;
         acc = acc + ring_mem[pos];
      end
      return acc;
   endfunction

   function automatic logic [MEAN_W-1:0] q16_mean(logic [SUM_W-1:0] sum,
                                                  logic [FILL_W-1:0] n);
      logic [DVD_W-1:0] quo;
      if (n == 0)
         return '0;
      quo = {sum, {FRAC_W{1'b0}}} / DVD_W'(n);
      return quo[MEAN_W-1:0];
   endfunction

   function automatic void clear_ring();
      for (int i = 0; i < RING_DEPTH; i++)
         ring_mem[i] = '0;
      head = '0;
      fill = '0;
   endfunction

   function automatic void predict_stats(op_type op, logic [SAMPLE_W-1:0] sample);
      logic [FILL_W-1:0] n;
      logic [HEAD_W-1:0] last_pos;
      window_stats_type  s;
      if (op == OP_CLEAR) begin
         clear_ring();
      end else begin
         ring_mem[head] = sample;
         head = head + 1'b1;
         if (fill < RING_DEPTH)
            fill = fill + 1'b1;
      end
      n = (window < fill) ? window : fill;
      last_pos = head - 1'b1;
      s.recent_sum    = newest_sum(n);
      s.recent_mean   = q16_mean(s.recent_sum, n);
      s.total_sum     = newest_sum(fill);
      s.total_mean    = q16_mean(s.total_sum, fill);
      s.latest_sample = (fill != 0) ? ring_mem[last_pos] : '0;
      s.fill_count    = fill;
      s.is_empty      = (fill == 0);
      stats_q.push_back(s);
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         fail_total++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      window_stats_type got;
      window_stats_type want;
      if (reset) begin
         clear_ring();
         window = WINDOW_RESET;
         stats_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            window = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            result_total++;
            got.recent_sum    = rsp_tdata[RS_LO +: SUM_W];
            got.recent_mean   = rsp_tdata[RM_LO +: MEAN_W];
            got.total_sum     = rsp_tdata[TS_LO +: SUM_W];
            got.total_mean    = rsp_tdata[TM_LO +: MEAN_W];
            got.latest_sample = rsp_tdata[LS_LO +: SAMPLE_W];
            got.fill_count    = rsp_tdata[FC_LO +: FILL_W];
            got.is_empty      = rsp_tuser;
            if (stats_q.size() == 0) begin
               fail_total++;
               $error("result item arrived with no item pending");
            end else begin
               want = stats_q.pop_front();
               compare_field("recent_sum", want.recent_sum, got.recent_sum);
               compare_field("recent_mean", want.recent_mean, got.recent_mean);
               compare_field("total_sum", want.total_sum, got.total_sum);
               compare_field("total_mean", want.total_mean, got.total_mean);
               compare_field("latest_sample", want.latest_sample, got.latest_sample);
               compare_field("fill_count", want.fill_count, got.fill_count);
               compare_field("is_empty", want.is_empty, got.is_empty);
            end
         end
         if (req_tvalid && req_tready)
            predict_stats(op_type'(req_tuser), req_tdata);
      end
      outstanding <= stats_q.size();
   end

endmodule

/* tb/sv/ring_window_sum_mean_unit_tb.sv */
// Testbench top for the ring window sum and mean unit: stimulus, pacing and verdict.
module ring_window_sum_mean_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rwsm_pkg::*;

   localparam int HOLD_CYCLES    = 1500;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 300;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_ITEMS    = 84;
   localparam int PRESSURE_PHASE = 3;
   localparam int PRESSURE_ITEMS = 40;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [WIN_W-1:0]      csr_data = '0;

   int mismatches;
   int outstanding;
   int checked;

   bit hold_off_req = 1'b0;
   bit hold_off_done = 1'b0;
   int burst_left = 0;
   int idle_cycles = 0;
   int push_total = 0;
   int clear_total = 0;
   int window_writes = 0;

   always #10 clock = ~clock;

   ring_window_sum_mean_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   ring_window_sum_mean_unit_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   task automatic send_item(op_type op, logic [SAMPLE_W-1:0] sample);
      req_tuser  <= op;
      req_tdata  <= sample;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (op == OP_CLEAR)
         clear_total++;
      else
         push_total++;
   endtask

   task automatic pace();
      int gap;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(1, 8);
            2: gap = $urandom_range(9, 60);
            default: gap = $urandom_range(61, 220);
         endcase
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // lets the checker's pending count catch up with the last accept, then waits until it is zero
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_window(logic [WIN_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_writes++;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 15);
         3: return 32'h8000_0000 | $urandom;
         default: return $urandom;
      endcase
   endfunction

   // receiver: segments of differing readiness, plus one long hold-off on request
   initial begin
      int mode;
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
               case (mode)
                  0: rsp_tready <= 1'b1;
                  1: rsp_tready <= $urandom_range(0, 1);
                  2: rsp_tready <= ($urandom_range(0, 19) == 0);
                  default: rsp_tready <= ($urandom_range(0, 9) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int win;
      bit back_to_back;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset window of 64, longer than the fill
      send_item(OP_CLEAR, 32'hFFFF_FFFF);
      send_item(OP_PUSH, 32'h0000_0000);
      send_item(OP_PUSH, 32'hFFFF_FFFF);
      send_item(OP_PUSH, 32'h0000_0001);
      send_item(OP_PUSH, 32'h8000_0000);
      send_item(OP_CLEAR, 32'h5A5A_5A5A);
      send_item(OP_PUSH, 32'h0000_0007);
      send_item(OP_PUSH, 32'hFFFF_FFFE);
      drain();

      // zero window: totals only
      write_window(7'd0);
      send_item(OP_PUSH, 32'h0000_0005);
      send_item(OP_PUSH, 32'hFFFF_FFFF);
      send_item(OP_CLEAR, 32'h0000_0000);
      drain();

      write_window(7'd1);
      send_item(OP_PUSH, 32'h0000_0003);
      send_item(OP_PUSH, 32'hFFFF_FFFF);
      send_item(OP_PUSH, 32'h0000_0000);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         case (phase)
            0: win = 64;
            1: win = 0;
            2: win = 1;
            3: win = 63;
            default: win = $urandom_range(0, 64);
         endcase
         write_window(WIN_W'(win));
         if (phase == 0)
            send_item(OP_CLEAR, $urandom);
         if (phase == PRESSURE_PHASE)
            hold_off_req <= 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            back_to_back = (phase == PRESSURE_PHASE) && (i < PRESSURE_ITEMS);
            if (phase == 0)
               send_item(OP_PUSH, '1);   // full ring of maximum samples
            else if (!back_to_back && $urandom_range(0, 99) < 2)
               send_item(OP_CLEAR, $urandom);
            else
               send_item(OP_PUSH, pick_sample());
            if (!back_to_back)
               pace();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d pushes and %0d ring clears across %0d window writes,",
               push_total, clear_total, window_writes);
      $display("%0d result items checked, including a saturated ring and a long output stall.",
               checked);
      if (mismatches == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
